FILE: rtl/lds_pkg.sv
// shared types and register codes for the look disk seek scheduler
`timescale 1ns / 1ps
package lds_pkg;

  // configuration register index port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_POS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd1;

  // sweep direction codes
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // classification attached to each queued request
  typedef struct packed {
    logic last;   // closes the batch
    logic keep;   // fits in the request store
    logic lower;  // strictly below the head position
  } lds_tag_t;

  // queue status seen by producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } lds_q_stat_t;

endpackage

FILE: rtl/lds_if.sv
// channel interfaces: requests, results and configuration writes
`timescale 1ns / 1ps
interface lds_req_if #(parameter int TRACK_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] track;
  logic                  last;

  modport source (output valid, output track, output last, input ready);
  modport sink   (input valid, input track, input last, output ready);
endinterface

interface lds_res_if #(parameter int TRACK_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] served_track;
  logic [TRACK_BITS-1:0] seek_distance;
  logic [TRACK_BITS:0]   total_seek;
  logic                  final_res;

  modport source (output valid, output served_track, output seek_distance,
                  output total_seek, output final_res, input ready);
  modport sink   (input valid, input served_track, input seek_distance,
                  input total_seek, input final_res, output ready);
endinterface

interface lds_cfg_if #(parameter int DATA_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic [lds_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_BITS-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/lds_front.sv
// request intake: batch counting, overflow flagging and head-side classification
`timescale 1ns / 1ps
module lds_front #(
  parameter int MAX_REQUESTS = 16,
  parameter int TRACK_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  lds_req_if.sink                 in_ch,
  input  logic [TRACK_BITS-1:0]   head_pos,
  input  lds_pkg::lds_q_stat_t    q_stat,
  output logic                    push,
  output logic [$bits(lds_pkg::lds_tag_t)+TRACK_BITS-1:0] push_entry
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  lds_pkg::lds_tag_t tag;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    tag.last  = in_ch.last;
    tag.keep  = count_r < CNT_W'(MAX_REQUESTS);
    tag.lower = in_ch.track < head_pos;
  end

  assign push_entry = {tag, in_ch.track};

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      if (in_ch.last) begin
        count_nxt = '0;
      end else if (tag.keep) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/lds_queue.sv
// small first-word fall-through queue between intake and scheduler
`timescale 1ns / 1ps
module lds_queue #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output lds_pkg::lds_q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign stat.full  = count_r == CNT_W'(DEPTH);
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/lds_back.sv
// scheduler: sorted insertion into cells, then look-order emission
`timescale 1ns / 1ps
module lds_back #(
  parameter int MAX_REQUESTS = 16,
  parameter int TRACK_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TRACK_BITS-1:0] head_pos,
  input  logic                  dir,
  input  logic [$bits(lds_pkg::lds_tag_t)+TRACK_BITS-1:0] q_entry,
  input  lds_pkg::lds_q_stat_t  q_stat,
  output logic                  q_pop,
  lds_res_if.source             out_ch
);

  localparam int CNT_W   = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int ENTRY_W = $bits(lds_pkg::lds_tag_t) + TRACK_BITS;

  localparam logic [1:0] PH_LOAD  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_EMIT  = 2'd2;

  logic [1:0]            phase_r, phase_nxt;
  logic [TRACK_BITS-1:0] cells_r   [MAX_REQUESTS];
  logic [TRACK_BITS-1:0] cells_nxt [MAX_REQUESTS];
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      nlow_r, nlow_nxt;
  logic [CNT_W-1:0]      remain_r, remain_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic                  up_r, up_nxt;
  logic [TRACK_BITS-1:0] pos_r, pos_nxt;
  logic [TRACK_BITS:0]   total_r, total_nxt;

  logic [TRACK_BITS-1:0] out_track_r, out_dist_r;
  logic [TRACK_BITS:0]   out_total_r;
  logic                  out_final_r, out_valid_r, out_valid_nxt;

  lds_pkg::lds_tag_t     q_tag;
  logic [TRACK_BITS-1:0] q_track;
  logic [MAX_REQUESTS-1:0] gt, sh;
  logic                  ins_en, advance, start_up;
  logic [TRACK_BITS-1:0] rd_track, seek_dist;
  logic [CNT_W-1:0]      ptr_inc, nlow_dec;

  assign q_tag   = lds_pkg::lds_tag_t'(q_entry[ENTRY_W-1:TRACK_BITS]);
  assign q_track = q_entry[TRACK_BITS-1:0];
  assign q_pop   = (phase_r == PH_LOAD) && !q_stat.empty;
  assign ins_en  = q_pop && q_tag.keep;

  // insertion: entries above the new value move up one cell
  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i] = (CNT_W'(i) < n_r) && (cells_r[i] > q_track);
    end
    sh = MAX_REQUESTS'({gt, 1'b0});
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      if (sh[i]) begin
        cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || (CNT_W'(i) == n_r)) begin
        cells_nxt[i] = q_track;
      end else begin
        cells_nxt[i] = cells_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      cells_r <= cells_nxt;
    end
  end

  // emission datapath
  assign advance   = (phase_r == PH_EMIT) && (!out_valid_r || out_ch.ready);
  assign rd_track  = cells_r[ptr_r];
  assign seek_dist = (pos_r >= rd_track) ? pos_r - rd_track : rd_track - pos_r;
  assign ptr_inc   = CNT_W'(ptr_r) + 1'b1;
  assign nlow_dec  = nlow_r - 1'b1;
  assign start_up  = (dir == lds_pkg::DIR_UP) ? (nlow_r < n_r) : (nlow_r == '0);

  always_comb begin
    phase_nxt  = phase_r;
    n_nxt      = n_r;
    nlow_nxt   = nlow_r;
    remain_nxt = remain_r;
    ptr_nxt    = ptr_r;
    up_nxt     = up_r;
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    unique case (phase_r)
      PH_LOAD: begin
        if (q_pop) begin
          if (ins_en) begin
            n_nxt = n_r + 1'b1;
            if (q_tag.lower) begin
              nlow_nxt = nlow_r + 1'b1;
            end
          end
          if (q_tag.last) begin
            phase_nxt = PH_START;
          end
        end
      end
      PH_START: begin
        remain_nxt = n_r;
        up_nxt     = start_up;
        ptr_nxt    = start_up ? IDX_W'(nlow_r) : IDX_W'(nlow_dec);
        pos_nxt    = head_pos;
        total_nxt  = '0;
        phase_nxt  = PH_EMIT;
      end
      PH_EMIT: begin
        if (advance) begin
          pos_nxt    = rd_track;
          total_nxt  = total_r + {1'b0, seek_dist};
          remain_nxt = remain_r - 1'b1;
          if (up_r) begin
            if (ptr_inc < n_r) begin
              ptr_nxt = IDX_W'(ptr_inc);
            end else begin
              ptr_nxt = IDX_W'(nlow_dec);
              up_nxt  = 1'b0;
            end
          end else begin
            if (ptr_r != '0) begin
              ptr_nxt = ptr_r - 1'b1;
            end else begin
              ptr_nxt = IDX_W'(nlow_r);
              up_nxt  = 1'b1;
            end
          end
          if (remain_r == CNT_W'(1)) begin
            phase_nxt = PH_LOAD;
            n_nxt     = '0;
            nlow_nxt  = '0;
          end
        end
      end
      default: phase_nxt = PH_LOAD;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOAD;
      n_r         <= '0;
      nlow_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      n_r         <= n_nxt;
      nlow_r      <= nlow_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    up_r    <= up_nxt;
    pos_r   <= pos_nxt;
    total_r <= total_nxt;
    if (advance) begin
      out_track_r <= rd_track;
      out_dist_r  <= seek_dist;
      out_total_r <= total_r + {1'b0, seek_dist};
      out_final_r <= remain_r == CNT_W'(1);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.served_track  = out_track_r;
  assign out_ch.seek_distance = out_dist_r;
  assign out_ch.total_seek    = out_total_r;
  assign out_ch.final_res     = out_final_r;

  a_low_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    nlow_r <= n_r)
    else $error("lower-side count exceeds stored count");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EMIT) |-> (CNT_W'(ptr_r) < n_r))
    else $error("read pointer outside stored entries");

  for (genvar g = 0; g + 1 < MAX_REQUESTS; g++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (CNT_W'(g + 1) < n_r) |-> (cells_r[g] <= cells_r[g + 1]))
      else $error("request cells out of order");
  end

endmodule

FILE: rtl/look_disk_seek_scheduler.sv
// top level of the look disk seek scheduler with configuration registers
`timescale 1ns / 1ps
//
//  channel  dir  handshake    payload
//  in_ch    in   valid/ready  track, last
//  out_ch   out  valid/ready  served_track, seek_distance, total_seek, final_res
//  cfg_ch   in   valid/ready  index (0 head_position, 1 direction), data
//
//  requests are taken one per cycle while the queue has room; each lands in the
//  sorted cell row at the edge it leaves the queue
//  after the last request: a setup state, then one result per cycle while
//  out_ch is taken, set by the single read port of the cell row
//  while a batch is emitted, the next batch is queued (up to the queue depth)
//  synchronous active-low reset clears control and the configuration registers to zero;
//  the request cells are not cleared and need no clearing pass
//  a stalled out_ch holds the result register and stops emission only;
//  intake keeps filling the queue until it is full
//
module look_disk_seek_scheduler #(
  parameter int MAX_REQUESTS = 16,
  parameter int TRACK_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lds_req_if.sink   in_ch,
  lds_res_if.source out_ch,
  lds_cfg_if.sink   cfg_ch
);

  // queue between intake and scheduler
  localparam int Q_DEPTH = 4;
  localparam int ENTRY_W = $bits(lds_pkg::lds_tag_t) + TRACK_BITS;

  // configuration registers
  logic [TRACK_BITS-1:0] head_r;
  logic                  dir_r;

  logic                 q_push, q_pop;
  logic [ENTRY_W-1:0]   q_push_entry, q_pop_entry;
  lds_pkg::lds_q_stat_t q_stat;

  // writes are always taken; unknown indexes are ignored
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      dir_r  <= lds_pkg::DIR_UP;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        lds_pkg::REG_HEAD_POS:  head_r <= cfg_ch.data;
        lds_pkg::REG_DIRECTION: dir_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // intake: counts the batch, flags overflow and the side of the head
  lds_front #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head_pos   (head_r),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // decoupling queue
  lds_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_entry),
    .pop       (q_pop),
    .pop_data  (q_pop_entry),
    .stat      (q_stat)
  );

  // scheduler: sorts the batch and emits look order with seek totals
  lds_back #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_pos (head_r),
    .dir      (dir_r),
    .q_entry  (q_pop_entry),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
